// ----- hw/rtl/ttwm_pkg.sv -----
// Shared types, codes and helpers of the tagged text width measure block.
package ttwm_pkg;

   localparam int GLYPH_ENTRIES   = 256;
   localparam int SPECIAL_ENTRIES = 32;
   localparam int CHAR_ENTRIES    = 256;

   localparam int GLYPH_AW = $clog2(GLYPH_ENTRIES);
   localparam int SPEC_AW  = $clog2(SPECIAL_ENTRIES);
   localparam int CHAR_AW  = $clog2(CHAR_ENTRIES);

   localparam int ACTION_W = 3;
   localparam int CHAR_W   = 8;
   localparam int GLYPH_W  = 8;
   localparam int VALUE_W  = 16;
   localparam int TWIDTH_W = 24;
   localparam int HEIGHT_W = 16;
   localparam int CSR_AW   = 2;
   localparam int CSR_DW   = 16;

   // Input actions
   localparam logic [ACTION_W-1:0] ACT_MAIN_MAP   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_MAIN_SPEC  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_MAIN_WIDTH = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_BTN_SPEC   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_BTN_WIDTH  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_MEASURE    = 3'd5;

   // Register indexes
   localparam logic [CSR_AW-1:0] CSR_LETTER_GAP     = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SPACE_ADVANCE  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_DEFAULT_HEIGHT = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CHAR_LC_C      = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_UC_C      = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_LC_S      = 8'h73;
   localparam logic [CHAR_W-1:0] CHAR_UC_S      = 8'h53;
   localparam logic [CHAR_W-1:0] CHAR_LC_B      = 8'h62;
   localparam logic [CHAR_W-1:0] CHAR_UC_B      = 8'h42;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9   = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LC_A      = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_F      = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UC_A      = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_F      = 8'h46;

   localparam logic signed [TWIDTH_W+1:0] WIDTH_MAX = 26'sd8388607;
   localparam logic signed [TWIDTH_W+1:0] WIDTH_MIN = -26'sd8388608;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAP,
      ST_WID
   } state_type;

   typedef enum logic [2:0] {
      PH_NORMAL,
      PH_ESCAPE,
      PH_SKIP,
      PH_MAIN_DIGIT,
      PH_BUTTON_DIGIT
   } phase_type;

   typedef enum logic [2:0] {
      K_NONE,
      K_SPACE,
      K_MAIN_CHAR,
      K_MAIN_SPEC,
      K_BTN_SPEC,
      K_END
   } kind_type;

   typedef enum logic [1:0] {
      SEL_CHAR,
      SEL_MAIN_SPEC,
      SEL_BTN_SPEC
   } map_sel_type;

   typedef struct packed {
      logic                char_we;
      logic                main_spec_we;
      logic                btn_spec_we;
      logic [CHAR_W-1:0]   addr;
      logic [GLYPH_W-1:0]  data;
   } map_wr_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_addr;
      logic [3:0]        digit;
      map_sel_type       sel;
   } map_rd_type;

   typedef struct packed {
      logic               step;
      logic               is_end;
      logic [VALUE_W-1:0] amount;
   } accum_ctl_type;

   // Non-hex characters count as digit zero
   function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
      logic [3:0] d;
      d = 4'd0;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
         d = 4'(c - CHAR_DIGIT_0);
      end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
         d = 4'(c - CHAR_LC_A + 8'd10);
      end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
         d = 4'(c - CHAR_UC_A + 8'd10);
      end
      return d;
   endfunction

endpackage

// ----- hw/rtl/ttwm_req_if.sv -----
// Input item channel of the tagged text width measure block.
interface ttwm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  table_index;
   logic [15:0] table_value;
   logic [7:0]  char_code;

   modport source (output valid, action, table_index, table_value, char_code, input ready);
   modport sink   (input valid, action, table_index, table_value, char_code, output ready);
endinterface

// ----- hw/rtl/ttwm_rsp_if.sv -----
// Result channel of the tagged text width measure block.
interface ttwm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] text_width;
   logic [15:0]        text_height;

   modport source (output valid, text_width, text_height, input ready);
   modport sink   (input valid, text_width, text_height, output ready);
endinterface

// ----- hw/rtl/ttwm_csr_if.sv -----
// Register write channel of the tagged text width measure block.
interface ttwm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ttwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ttwm_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/ttwm_maps.sv -----
// Character and special glyph maps: three RAMs zeroed by a clearing pass after reset.
module ttwm_maps (
   input  logic                  clock,
   input  logic                  reset,
   input  ttwm_pkg::map_wr_type  wr,
   input  ttwm_pkg::map_rd_type  rd,
   output logic                  clearing,
   output logic [7:0]            glyph
);
   import ttwm_pkg::*;

   logic [GLYPH_W-1:0] char_q;
   logic [GLYPH_W-1:0] main_spec_q;
   logic [GLYPH_W-1:0] btn_spec_q;
   logic [SPEC_AW-1:0] spec_raddr;
   logic [SPEC_AW-1:0] spec_waddr;
   logic [CHAR_AW-1:0] char_waddr;
   logic [GLYPH_W-1:0] map_wdata;
   logic               char_we, main_spec_we, btn_spec_we;

   logic               clear_ff, clear_in;
   logic [CHAR_AW-1:0] clear_addr_ff, clear_addr_in;
   map_sel_type        sel_ff;

   // Sweep the char map once after reset; the special maps see their low address bits
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + CHAR_AW'(1);
         if (clear_addr_ff == CHAR_AW'(CHAR_ENTRIES - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign clearing     = clear_ff;
   assign char_we      = clear_ff || wr.char_we;
   assign main_spec_we = clear_ff || wr.main_spec_we;
   assign btn_spec_we  = clear_ff || wr.btn_spec_we;
   assign char_waddr   = clear_ff ? clear_addr_ff : wr.addr[CHAR_AW-1:0];
   assign spec_waddr   = clear_ff ? clear_addr_ff[SPEC_AW-1:0] : wr.addr[SPEC_AW-1:0];
   assign map_wdata    = clear_ff ? '0 : wr.data;
   assign spec_raddr   = SPEC_AW'(rd.digit);

   ttwm_ram #(.WIDTH(GLYPH_W), .DEPTH(CHAR_ENTRIES)) u_char_map (
      .clock (clock),
      .we    (char_we),
      .waddr (char_waddr),
      .wdata (map_wdata),
      .raddr (rd.char_addr[CHAR_AW-1:0]),
      .rdata (char_q)
   );

   ttwm_ram #(.WIDTH(GLYPH_W), .DEPTH(SPECIAL_ENTRIES)) u_main_spec_map (
      .clock (clock),
      .we    (main_spec_we),
      .waddr (spec_waddr),
      .wdata (map_wdata),
      .raddr (spec_raddr),
      .rdata (main_spec_q)
   );

   ttwm_ram #(.WIDTH(GLYPH_W), .DEPTH(SPECIAL_ENTRIES)) u_btn_spec_map (
      .clock (clock),
      .we    (btn_spec_we),
      .waddr (spec_waddr),
      .wdata (map_wdata),
      .raddr (spec_raddr),
      .rdata (btn_spec_q)
   );

   // Select is registered alongside the RAM read, so it lines up with the read data
   always_ff @(posedge clock) begin
      sel_ff <= rd.sel;
   end

   always_comb begin
      case (sel_ff)
         SEL_CHAR:      glyph = char_q;
         SEL_MAIN_SPEC: glyph = main_spec_q;
         SEL_BTN_SPEC:  glyph = btn_spec_q;
         default:       glyph = '0;
      endcase
   end

endmodule

// ----- hw/rtl/ttwm_accum.sv -----
// Saturating running-width accumulator and result register.
module ttwm_accum (
   input  logic                    clock,
   input  logic                    reset,
   input  ttwm_pkg::accum_ctl_type ctl,
   input  logic signed [7:0]       letter_gap,
   input  logic [15:0]             height,
   output logic                    busy,
   ttwm_rsp_if.source              rsp_bus
);
   import ttwm_pkg::*;

   logic signed [TWIDTH_W-1:0] run_ff, run_in;
   logic signed [TWIDTH_W-1:0] width_ff, width_in;
   logic [HEIGHT_W-1:0]        height_ff, height_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [TWIDTH_W+1:0] sum;

   assign sum = (TWIDTH_W+2)'(run_ff)
              + $signed({{(TWIDTH_W+2-VALUE_W){1'b0}}, ctl.amount})
              + (TWIDTH_W+2)'(letter_gap);

   assign busy = rsp_valid_ff && !rsp_bus.ready;

   always_comb begin
      run_in       = run_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (ctl.step) begin
         if (ctl.is_end) begin
            width_in     = run_ff;
            height_in    = height;
            rsp_valid_in = 1'b1;
            run_in       = '0;
         end else if (sum > WIDTH_MAX) begin
            run_in = WIDTH_MAX[TWIDTH_W-1:0];
         end else if (sum < WIDTH_MIN) begin
            run_in = WIDTH_MIN[TWIDTH_W-1:0];
         end else begin
            run_in = sum[TWIDTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff  <= width_in;
      height_ff <= height_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.text_width  = width_ff;
   assign rsp_bus.text_height = height_ff;

endmodule

// ----- hw/rtl/tagged_text_width_measure.sv -----
// Top level of the tagged text width measure block: tag parser, width RAMs and control.
//
// Table write actions can be sent in every cycle but not while a measure reads its map.
// For a measure action the character or special map RAM is read in the cycle of the
// transfer, the glyph width RAM is read in the next, and the width is added to the
// running total in the cycle after that, while the next item is already taken in, so a
// new measured character is taken while the last is added. The string end result sits
// in an output register; the block keeps taking items while it waits there, and only
// a second string end that reaches the add step before the first result is taken
// holds the input. After reset the maps are zeroed by a clearing pass, one entry a
// cycle, during which the input is held off; register writes are taken at once.
module tagged_text_width_measure (
   input  logic       clock,
   input  logic       reset,
   ttwm_req_if.sink   req_bus,
   ttwm_rsp_if.source rsp_bus,
   ttwm_csr_if.sink   csr_bus
);
   import ttwm_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   kind_type  kind_ff, kind_in;
   kind_type  plain_kind;

   logic signed [7:0]   letter_gap_ff;
   logic [VALUE_W-1:0]  space_adv_ff;
   logic [HEIGHT_W-1:0] default_height_ff;

   logic               accept, measure, stall, out_busy, clearing;
   logic [CHAR_W-1:0]  c;
   logic [GLYPH_W-1:0] glyph;
   logic               glyph_ok_ff;
   logic [VALUE_W-1:0] main_w_q, btn_w_q;
   logic               main_w_we, btn_w_we;

   map_wr_type    map_wr;
   map_rd_type    map_rd;
   accum_ctl_type acc_ctl;
   accum_ctl_type acc_ctl_gated;

   // Registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_gap_ff     <= '0;
         space_adv_ff      <= '0;
         default_height_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_LETTER_GAP:     letter_gap_ff     <= $signed(csr_bus.data[7:0]);
            CSR_SPACE_ADVANCE:  space_adv_ff      <= csr_bus.data;
            CSR_DEFAULT_HEIGHT: default_height_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Input transfer
   assign c       = req_bus.char_code;
   assign stall   = (state_ff == ST_WID) && (kind_ff == K_END) && out_busy;
   assign req_bus.ready = !clearing
                          && ((state_ff == ST_IDLE) || ((state_ff == ST_WID) && !stall));
   assign accept  = req_bus.valid && req_bus.ready;
   assign measure = accept && (req_bus.action == ACT_MEASURE);

   assign plain_kind = (c == CHAR_SPACE) ? K_SPACE : K_MAIN_CHAR;

   // Tag parser
   always_comb begin
      kind_in  = kind_ff;
      phase_in = phase_ff;
      if (measure) begin
         if (c == CHAR_NUL) begin
            kind_in  = K_END;
            phase_in = PH_NORMAL;
         end else begin
            case (phase_ff)
               PH_ESCAPE: begin
                  phase_in = PH_NORMAL;
                  kind_in  = K_NONE;
                  if (c == CHAR_LC_C || c == CHAR_UC_C) begin
                     phase_in = PH_SKIP;
                  end else if (c == CHAR_LC_S || c == CHAR_UC_S) begin
                     phase_in = PH_MAIN_DIGIT;
                  end else if (c == CHAR_LC_B || c == CHAR_UC_B) begin
                     phase_in = PH_BUTTON_DIGIT;
                  end else begin
                     kind_in = plain_kind;
                  end
               end
               PH_SKIP: begin
                  kind_in  = K_NONE;
                  phase_in = PH_NORMAL;
               end
               PH_MAIN_DIGIT: begin
                  kind_in  = K_MAIN_SPEC;
                  phase_in = PH_NORMAL;
               end
               PH_BUTTON_DIGIT: begin
                  kind_in  = K_BTN_SPEC;
                  phase_in = PH_NORMAL;
               end
               default: begin
                  if (c == CHAR_BACKSLASH) begin
                     kind_in  = K_NONE;
                     phase_in = PH_ESCAPE;
                  end else begin
                     kind_in  = plain_kind;
                     phase_in = PH_NORMAL;
                  end
               end
            endcase
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (measure) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: state_in = ST_WID;
         ST_WID: begin
            if (!stall) begin
               state_in = measure ? ST_MAP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_NORMAL;
         kind_ff  <= K_NONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

   // Map stage
   always_comb begin
      map_wr.char_we      = accept && (req_bus.action == ACT_MAIN_MAP);
      map_wr.main_spec_we = accept && (req_bus.action == ACT_MAIN_SPEC)
                            && (req_bus.table_index < SPECIAL_ENTRIES);
      map_wr.btn_spec_we  = accept && (req_bus.action == ACT_BTN_SPEC)
                            && (req_bus.table_index < SPECIAL_ENTRIES);
      map_wr.addr         = req_bus.table_index;
      map_wr.data         = req_bus.table_value[GLYPH_W-1:0];
      map_rd.char_addr    = c;
      map_rd.digit        = hex_digit(c);
      case (kind_in)
         K_MAIN_SPEC: map_rd.sel = SEL_MAIN_SPEC;
         K_BTN_SPEC:  map_rd.sel = SEL_BTN_SPEC;
         default:     map_rd.sel = SEL_CHAR;
      endcase
   end

   ttwm_maps u_maps (
      .clock    (clock),
      .reset    (reset),
      .wr       (map_wr),
      .rd       (map_rd),
      .clearing (clearing),
      .glyph    (glyph)
   );

   // Width stage
   assign main_w_we = accept && (req_bus.action == ACT_MAIN_WIDTH)
                      && (req_bus.table_index < GLYPH_ENTRIES);
   assign btn_w_we  = accept && (req_bus.action == ACT_BTN_WIDTH)
                      && (req_bus.table_index < GLYPH_ENTRIES);

   ttwm_ram #(.WIDTH(VALUE_W), .DEPTH(GLYPH_ENTRIES)) u_main_width (
      .clock (clock),
      .we    (main_w_we),
      .waddr (req_bus.table_index[GLYPH_AW-1:0]),
      .wdata (req_bus.table_value),
      .raddr (glyph[GLYPH_AW-1:0]),
      .rdata (main_w_q)
   );

   ttwm_ram #(.WIDTH(VALUE_W), .DEPTH(GLYPH_ENTRIES)) u_btn_width (
      .clock (clock),
      .we    (btn_w_we),
      .waddr (req_bus.table_index[GLYPH_AW-1:0]),
      .wdata (req_bus.table_value),
      .raddr (glyph[GLYPH_AW-1:0]),
      .rdata (btn_w_q)
   );

   // Glyphs beyond the width table measure zero
   always_ff @(posedge clock) begin
      glyph_ok_ff <= ({1'b0, glyph} < (GLYPH_W+1)'(GLYPH_ENTRIES));
   end

   // Accumulate stage
   always_comb begin
      acc_ctl.step   = (state_ff == ST_WID) && !stall;
      acc_ctl.is_end = (kind_ff == K_END);
      case (kind_ff)
         K_SPACE:     acc_ctl.amount = space_adv_ff;
         K_MAIN_CHAR: acc_ctl.amount = glyph_ok_ff ? main_w_q : '0;
         K_MAIN_SPEC: acc_ctl.amount = glyph_ok_ff ? main_w_q : '0;
         K_BTN_SPEC:  acc_ctl.amount = glyph_ok_ff ? btn_w_q : '0;
         default:     acc_ctl.amount = '0;
      endcase
   end

   // Tag-only characters still pass the adder; hold them out of it
   always_comb begin
      acc_ctl_gated      = acc_ctl;
      acc_ctl_gated.step = acc_ctl.step && (kind_ff != K_NONE);
   end

   ttwm_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .ctl        (acc_ctl_gated),
      .letter_gap (letter_gap_ff),
      .height     (default_height_ff),
      .busy       (out_busy),
      .rsp_bus    (rsp_bus)
   );

   // Checks
   a_no_accept_in_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP) |-> !req_bus.ready)
      else $error("input transfer offered during map read");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_bus.ready)
      else $error("input transfer offered during map clearing");

   a_measure_to_map: assert property (@(posedge clock) disable iff (reset)
      measure |=> (state_ff == ST_MAP))
      else $error("measure transfer did not start a map read");

   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past((state_ff == ST_WID) && (kind_ff == K_END)))
      else $error("result raised without a string end");

   a_end_clears_phase: assert property (@(posedge clock) disable iff (reset)
      (measure && (c == CHAR_NUL)) |=> (phase_ff == PH_NORMAL))
      else $error("string end left a tag open");

endmodule
